/* rtl/uapq_pkg.sv */
// Shared types and constants for the unsorted-array priority queue.
// No dependencies; the other files that use it refer to this package by scoped names.
`default_nettype none

package uapq_pkg;

    // Field widths of one input word and one result word
    localparam int ACTION_W   = 2;
    localparam int VERTEX_W   = 16;
    localparam int PRIO_W     = 32;
    localparam int STATUS_W   = 3;
    localparam int COUNT_W    = 7;
    localparam int ENTRY_W    = VERTEX_W + PRIO_W;
    localparam int S_TDATA_W  = 56;
    localparam int M_TDATA_W  = 32;

    typedef enum logic [ACTION_W-1:0] {
        ACT_INSERT   = 2'd0,
        ACT_EXTRACT  = 2'd1,
        ACT_DECREASE = 2'd2,
        ACT_CONTAINS = 2'd3
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 3'd0,
        ST_FULL       = 3'd1,
        ST_DUP        = 3'd2,
        ST_EMPTY      = 3'd3,
        ST_NOTFOUND   = 3'd4,
        ST_NOTSMALLER = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_DECIDE,
        S_FINISH
    } ctrl_state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic load_in;
        logic scan_init;
        logic scan;
        logic decide;
        logic load_out;
    } dp_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic skip_scan;
        logic scan_done;
        logic out_free;
    } dp_stat_t;

endpackage

`default_nettype wire

/* rtl/uapq_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module uapq_ram #(
    parameter int WIDTH  = 48,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

/* rtl/uapq_ctrl.sv */
// Controller state machine: sequences accept, scan, decide and result load.
// Depends on uapq_pkg for the state, command and status types.
`default_nettype none

module uapq_ctrl (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire uapq_pkg::dp_stat_t  stat,
    output uapq_pkg::dp_cmd_t        cmd
);

    uapq_pkg::ctrl_state_t state_reg, state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= uapq_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            uapq_pkg::S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    state_next  = uapq_pkg::S_CHECK;
                end
            end
            uapq_pkg::S_CHECK: begin
                cmd.scan_init = 1'b1;
                state_next    = stat.skip_scan ? uapq_pkg::S_DECIDE : uapq_pkg::S_SCAN;
            end
            uapq_pkg::S_SCAN: begin
                cmd.scan = 1'b1;
                if (stat.scan_done) begin
                    state_next = uapq_pkg::S_DECIDE;
                end
            end
            uapq_pkg::S_DECIDE: begin
                cmd.decide = 1'b1;
                state_next = uapq_pkg::S_FINISH;
            end
            uapq_pkg::S_FINISH: begin
                if (stat.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = uapq_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = uapq_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* rtl/uapq_dp.sv */
// Datapath: request registers, entry count, scan pointer, match and minimum
// trackers, the entry RAM and the output register. Depends on uapq_pkg, uapq_ram.
`default_nettype none

module uapq_dp #(
    parameter int CAPACITY = 64
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic [uapq_pkg::S_TDATA_W-1:0]    s_tdata,
    input  wire logic                              m_tready,
    output logic                                   m_tvalid,
    output logic      [uapq_pkg::M_TDATA_W-1:0]    m_tdata,
    input  wire uapq_pkg::dp_cmd_t                 cmd,
    output uapq_pkg::dp_stat_t                     stat
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    // Request
    uapq_pkg::action_t                   op_reg;
    logic [uapq_pkg::VERTEX_W-1:0]       vert_reg;
    logic signed [uapq_pkg::PRIO_W-1:0]  prio_reg;

    // Occupancy and scan
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] rd_ptr_reg;
    logic          dvalid_reg;
    logic [AW-1:0] didx_reg;

    // Trackers
    logic                                hit_reg;
    logic [AW-1:0]                       hit_idx_reg;
    logic signed [uapq_pkg::PRIO_W-1:0]  hit_prio_reg;
    logic [AW-1:0]                       best_idx_reg;
    logic signed [uapq_pkg::PRIO_W-1:0]  best_prio_reg;
    logic [uapq_pkg::VERTEX_W-1:0]       best_vert_reg;
    logic [uapq_pkg::ENTRY_W-1:0]        last_reg;

    // Result
    uapq_pkg::status_t                   res_status_reg, res_status_next;
    logic [uapq_pkg::VERTEX_W-1:0]       res_minv_reg, res_minv_next;
    logic                                res_found_reg, res_found_next;
    logic                                m_tvalid_reg;
    logic [uapq_pkg::M_TDATA_W-1:0]      m_tdata_reg;

    // RAM ports
    logic                           wr_en;
    logic [AW-1:0]                  wr_addr;
    logic [uapq_pkg::ENTRY_W-1:0]   wr_data;
    logic                           rd_en;
    logic [uapq_pkg::ENTRY_W-1:0]   rd_data;

    logic [uapq_pkg::VERTEX_W-1:0]       rd_vert;
    logic signed [uapq_pkg::PRIO_W-1:0]  rd_prio;
    logic                                eval;
    logic                                is_full;
    logic                                all_issued;

    assign rd_vert    = rd_data[uapq_pkg::ENTRY_W-1:uapq_pkg::PRIO_W];
    assign rd_prio    = $signed(rd_data[uapq_pkg::PRIO_W-1:0]);
    assign is_full    = (count_reg >= CW'(CAPACITY));
    assign all_issued = (rd_ptr_reg == count_reg);
    assign rd_en      = cmd.scan && !all_issued && !hit_reg;
    assign eval       = cmd.scan && dvalid_reg && !hit_reg;

    assign stat.skip_scan = (count_reg == '0) || ((op_reg == uapq_pkg::ACT_INSERT) && is_full);
    assign stat.scan_done = hit_reg || (all_issued && !dvalid_reg);
    assign stat.out_free  = !m_tvalid_reg || m_tready;

    uapq_ram #(
        .WIDTH (uapq_pkg::ENTRY_W),
        .DEPTH (CAPACITY),
        .ADDR_W(AW)
    ) u_entries (
        .aclk   (aclk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_en  (rd_en),
        .rd_addr(rd_ptr_reg[AW-1:0]),
        .rd_data(rd_data)
    );

    // Latch the request word
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            op_reg   <= uapq_pkg::action_t'(s_tdata[uapq_pkg::ACTION_W-1:0]);
            vert_reg <= s_tdata[uapq_pkg::ACTION_W +: uapq_pkg::VERTEX_W];
            prio_reg <= $signed(s_tdata[uapq_pkg::ACTION_W + uapq_pkg::VERTEX_W +:
                                        uapq_pkg::PRIO_W]);
        end
    end

    // Advance the scan pointer, the read-data tag and the match flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_ptr_reg <= '0;
            dvalid_reg <= 1'b0;
            hit_reg    <= 1'b0;
        end else if (cmd.scan_init) begin
            rd_ptr_reg <= '0;
            dvalid_reg <= 1'b0;
            hit_reg    <= 1'b0;
        end else begin
            dvalid_reg <= rd_en;
            if (rd_en) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (eval && (op_reg != uapq_pkg::ACT_EXTRACT) && (rd_vert == vert_reg)) begin
                hit_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            didx_reg <= rd_ptr_reg[AW-1:0];
        end
    end

    // Track first match, running minimum and the last entry
    always_ff @(posedge aclk) begin
        if (eval) begin
            if (rd_vert == vert_reg) begin
                hit_idx_reg  <= didx_reg;
                hit_prio_reg <= rd_prio;
            end
            if ((didx_reg == '0) || (rd_prio < best_prio_reg)) begin
                best_idx_reg  <= didx_reg;
                best_prio_reg <= rd_prio;
                best_vert_reg <= rd_vert;
            end
            last_reg <= rd_data;
        end
    end

    // Decide result, write-back and new count
    always_comb begin
        wr_en           = 1'b0;
        wr_addr         = count_reg[AW-1:0];
        wr_data         = {vert_reg, prio_reg};
        count_next      = count_reg;
        res_status_next = uapq_pkg::ST_OK;
        res_minv_next   = '0;
        res_found_next  = 1'b0;
        if (cmd.decide) begin
            case (op_reg)
                uapq_pkg::ACT_INSERT: begin
                    if (is_full) begin
                        res_status_next = uapq_pkg::ST_FULL;
                    end else if (hit_reg) begin
                        res_status_next = uapq_pkg::ST_DUP;
                    end else begin
                        wr_en      = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                end
                uapq_pkg::ACT_EXTRACT: begin
                    if (count_reg == '0) begin
                        res_status_next = uapq_pkg::ST_EMPTY;
                    end else begin
                        res_minv_next = best_vert_reg;
                        wr_en         = 1'b1;
                        wr_addr       = best_idx_reg;
                        wr_data       = last_reg;
                        count_next    = count_reg - 1'b1;
                    end
                end
                uapq_pkg::ACT_DECREASE: begin
                    if (!hit_reg) begin
                        res_status_next = uapq_pkg::ST_NOTFOUND;
                    end else if (prio_reg >= hit_prio_reg) begin
                        res_status_next = uapq_pkg::ST_NOTSMALLER;
                    end else begin
                        wr_en   = 1'b1;
                        wr_addr = hit_idx_reg;
                    end
                end
                uapq_pkg::ACT_CONTAINS: begin
                    res_found_next = hit_reg;
                end
                default: begin
                    res_status_next = uapq_pkg::ST_OK;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.decide) begin
            res_status_reg <= res_status_next;
            res_minv_reg   <= res_minv_next;
            res_found_reg  <= res_found_next;
        end
    end

    // Hold the result word until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            m_tdata_reg <= {4'b0000,
                            (count_reg == '0),
                            uapq_pkg::COUNT_W'(count_reg),
                            res_found_reg,
                            res_minv_reg,
                            res_status_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

/* rtl/unsorted_array_priority_queue.sv */
// Top level of the unsorted-array priority queue with decrease-key.
// Depends on uapq_pkg, uapq_ctrl and uapq_dp (which holds uapq_ram).
//
//   Channel | Dir | Word
//   s_      | in  | one request: action, vertex, priority_req
//   m_      | out | one result: status, min_vertex, found, entry_count, is_empty
//
// One request at a time. From accept to result the entry RAM is read one entry
// per cycle over the live entries, ending early on the first vertex match;
// extract always reads them all. An empty queue, or an insert to a full
// queue, skips the read.
// Reset clears the count and all control state; the RAM needs no clearing.
// A result word waiting on m_tready holds the finish step but not the accept
// of the next request.
`default_nettype none

module unsorted_array_priority_queue #(
    parameter int CAPACITY = 64
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // [1:0] action, [17:2] vertex, [49:18] priority_req, [55:50] zero
    input  wire logic [uapq_pkg::S_TDATA_W-1:0]  s_tdata,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // [2:0] status, [18:3] min_vertex, [19] found, [26:20] entry_count,
    // [27] is_empty, [31:28] zero
    output logic      [uapq_pkg::M_TDATA_W-1:0]  m_tdata
);

    uapq_pkg::dp_cmd_t  cmd;
    uapq_pkg::dp_stat_t stat;

    uapq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .stat    (stat),
        .cmd     (cmd)
    );

    uapq_dp #(
        .CAPACITY(CAPACITY)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tdata (s_tdata),
        .m_tready(m_tready),
        .m_tvalid(m_tvalid),
        .m_tdata (m_tdata),
        .cmd     (cmd),
        .stat    (stat)
    );

endmodule

`default_nettype wire

/* tb/uapq_result_checker.sv */
// Result checker for the unsorted-array priority queue: it follows every request
// word, predicts its result word and compares the two field by field.
// Depends on uapq_pkg for widths, action codes and status codes.

module uapq_result_checker #(
    parameter int CAPACITY = 64
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    input  wire logic                            s_tready,
    input  wire logic [uapq_pkg::S_TDATA_W-1:0]  s_tdata,
    input  wire logic                            m_tvalid,
    input  wire logic                            m_tready,
    input  wire logic [uapq_pkg::M_TDATA_W-1:0]  m_tdata,
    output int                                   mismatch_count,
    output int                                   results_owed
);

    typedef struct {
        uapq_pkg::status_t               status;
        logic [uapq_pkg::VERTEX_W-1:0]   min_vertex;
        logic                            found;
        logic [uapq_pkg::COUNT_W-1:0]    entry_count;
        logic                            is_empty;
    } queue_result_t;

    // Shadow copy of the queue contents
    logic [uapq_pkg::VERTEX_W-1:0]        held_vertex [CAPACITY];
    logic signed [uapq_pkg::PRIO_W-1:0]   held_prio   [CAPACITY];
    int                                   held_count = 0;
    int                                   errs = 0;
    queue_result_t                        predicted_results [$];

    // Return the first live slot holding the vertex, or -1
    function automatic int find_slot(logic [uapq_pkg::VERTEX_W-1:0] vid);
        for (int i = 0; i < held_count; i++) begin
            if (held_vertex[i] == vid) return i;
        end
        return -1;
    endfunction

    // Apply one request to the shadow queue and return its result
    function automatic queue_result_t apply_request(uapq_pkg::action_t act,
                                                    logic [uapq_pkg::VERTEX_W-1:0] vid,
                                                    logic signed [uapq_pkg::PRIO_W-1:0] prio);
        queue_result_t r;
        int            hit;
        int            best;
        r.status     = uapq_pkg::ST_OK;
        r.min_vertex = '0;
        r.found      = 1'b0;
        hit          = find_slot(vid);
        case (act)
            uapq_pkg::ACT_INSERT: begin
                // fullness wins over the duplicate test
                if (held_count >= CAPACITY) begin
                    r.status = uapq_pkg::ST_FULL;
                end else if (hit >= 0) begin
                    r.status = uapq_pkg::ST_DUP;
                end else begin
                    held_vertex[held_count] = vid;
                    held_prio[held_count]   = prio;
                    held_count++;
                end
            end
            uapq_pkg::ACT_EXTRACT: begin
                if (held_count == 0) begin
                    r.status = uapq_pkg::ST_EMPTY;
                end else begin
                    // strict compare keeps the lowest index on ties
                    best = 0;
                    for (int i = 1; i < held_count; i++) begin
                        if (held_prio[i] < held_prio[best]) best = i;
                    end
                    r.min_vertex      = held_vertex[best];
                    held_vertex[best] = held_vertex[held_count-1];
                    held_prio[best]   = held_prio[held_count-1];
                    held_count--;
                end
            end
            uapq_pkg::ACT_DECREASE: begin
                if (hit < 0) begin
                    r.status = uapq_pkg::ST_NOTFOUND;
                end else if (prio >= held_prio[hit]) begin
                    r.status = uapq_pkg::ST_NOTSMALLER;
                end else begin
                    held_prio[hit] = prio;
                end
            end
            default: begin
                r.found = (hit >= 0);
            end
        endcase
        r.entry_count = uapq_pkg::COUNT_W'(held_count);
        r.is_empty    = (held_count == 0);
        return r;
    endfunction

    function automatic void check_field(string name, logic [31:0] want_v, logic [31:0] got_v);
        if (want_v !== got_v) begin
            $error("%s: expected %0d, got %0d", name, want_v, got_v);
            errs++;
        end
    endfunction

    always @(posedge aclk) begin
        queue_result_t want;
        if (!aresetn) begin
            held_count = 0;
            predicted_results.delete();
        end else begin
            // Compare each result word against the oldest prediction
            if (m_tvalid && m_tready) begin
                if (predicted_results.size() == 0) begin
                    $error("result word with no request outstanding");
                    errs++;
                end else begin
                    want = predicted_results.pop_front();
                    check_field("status", want.status, m_tdata[2:0]);
                    check_field("min_vertex", want.min_vertex, m_tdata[18:3]);
                    check_field("found", want.found, m_tdata[19]);
                    check_field("entry_count", want.entry_count, m_tdata[26:20]);
                    check_field("is_empty", want.is_empty, m_tdata[27]);
                end
            end
            // Predict the result of each accepted request word
            if (s_tvalid && s_tready) begin
                predicted_results.push_back(
                    apply_request(uapq_pkg::action_t'(s_tdata[1:0]),
                                  s_tdata[17:2], s_tdata[49:18]));
            end
        end
        results_owed   <= predicted_results.size();
        mismatch_count <= errs;
    end

endmodule

/* tb/unsorted_array_priority_queue_tb.sv */
// Testbench top for the unsorted-array priority queue: drives request words with
// random gaps and result backpressure, and gives the verdict.
// Depends on uapq_pkg, unsorted_array_priority_queue and uapq_result_checker.

module unsorted_array_priority_queue_tb;

    localparam int CAPACITY     = 64;
    localparam int RANDOM_WORDS = 1500;
    localparam int CYCLE_LIMIT  = 1_000_000;

    typedef enum {MIX_FILL, MIX_DRAIN, MIX_BALANCED} op_mix_t;

    logic                            aclk     = 1'b0;
    logic                            aresetn  = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [uapq_pkg::S_TDATA_W-1:0]  s_tdata  = '0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [uapq_pkg::M_TDATA_W-1:0]  m_tdata;
    int                              mismatch_count;
    int                              results_owed;
    int                              cycle_count = 0;
    bit                              steady = 1'b0;
    logic [uapq_pkg::VERTEX_W-1:0]   inserted_ids [$];

    unsorted_array_priority_queue #(.CAPACITY(CAPACITY)) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    uapq_result_checker #(.CAPACITY(CAPACITY)) u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .mismatch_count (mismatch_count),
        .results_owed   (results_owed)
    );

    always #5 aclk = ~aclk;

    // Mostly no gap, often a short one, now and then a long one
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (steady || roll < 50) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        return $urandom_range(12, 60);
    endfunction

    // Present one request word and hold it until accepted
    task automatic issue(uapq_pkg::action_t act, logic [uapq_pkg::VERTEX_W-1:0] vid,
                         logic [uapq_pkg::PRIO_W-1:0] prio);
        int gap;
        gap = pick_gap();
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= uapq_pkg::S_TDATA_W'({prio, vid, act});
        do @(posedge aclk); while (!s_tready);
    endtask

    // Stall the result channel in random bursts
    initial begin
        wait (aresetn);
        forever begin
            repeat ($urandom_range(1, 24)) begin
                @(negedge aclk);
                m_tready <= 1'b1;
            end
            repeat (pick_gap()) begin
                @(negedge aclk);
                m_tready <= 1'b0;
            end
        end
    end

    // Stop a hung run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        op_mix_t                        mix;
        int                             sent;
        int                             phase;
        int                             phase_len;
        int                             roll;
        int                             ins_pct;
        int                             ext_pct;
        int                             dec_pct;
        uapq_pkg::action_t              act;
        logic [uapq_pkg::VERTEX_W-1:0]  vid;
        logic [uapq_pkg::PRIO_W-1:0]    prio;

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: empty queue, field extremes, ties, every refusal but a full queue
        issue(uapq_pkg::ACT_CONTAINS, 16'h0000, 32'h0000_0000);
        issue(uapq_pkg::ACT_EXTRACT,  16'hFFFF, 32'hFFFF_FFFF);
        issue(uapq_pkg::ACT_DECREASE, 16'h0005, 32'h8000_0000);
        issue(uapq_pkg::ACT_INSERT,   16'h0000, 32'h7FFF_FFFF);
        issue(uapq_pkg::ACT_INSERT,   16'hFFFF, 32'h8000_0000);
        issue(uapq_pkg::ACT_INSERT,   16'h0000, 32'h0000_0000);
        issue(uapq_pkg::ACT_INSERT,   16'h1234, 32'hFFFF_FFFB);
        issue(uapq_pkg::ACT_INSERT,   16'h0ABC, 32'hFFFF_FFFB);
        issue(uapq_pkg::ACT_CONTAINS, 16'hFFFF, 32'h0000_0000);
        issue(uapq_pkg::ACT_CONTAINS, 16'h5555, 32'h0000_0000);
        issue(uapq_pkg::ACT_DECREASE, 16'h1234, 32'hFFFF_FFFB);
        issue(uapq_pkg::ACT_DECREASE, 16'h1234, 32'hFFFF_FFFC);
        issue(uapq_pkg::ACT_DECREASE, 16'h9999, 32'h8000_0000);
        issue(uapq_pkg::ACT_DECREASE, 16'h0000, 32'h8000_0000);
        issue(uapq_pkg::ACT_EXTRACT,  16'h0000, 32'h0000_0000);
        issue(uapq_pkg::ACT_EXTRACT,  16'h0000, 32'h0000_0000);
        issue(uapq_pkg::ACT_EXTRACT,  16'h0000, 32'h0000_0000);
        issue(uapq_pkg::ACT_EXTRACT,  16'h0000, 32'h0000_0000);
        issue(uapq_pkg::ACT_EXTRACT,  16'h0000, 32'h0000_0000);
        issue(uapq_pkg::ACT_INSERT,   16'hA5A5, 32'h0000_0001);
        issue(uapq_pkg::ACT_DECREASE, 16'hA5A5, 32'h8000_0000);
        issue(uapq_pkg::ACT_EXTRACT,  16'h0000, 32'h0000_0000);

        // Random phases; the first one fills the queue past full
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_WORDS) begin
            mix       = (phase == 0) ? MIX_FILL : op_mix_t'($urandom_range(0, 2));
            steady    = (phase % 4 == 3);
            phase_len = $urandom_range(100, 160);
            case (mix)
                MIX_FILL: begin
                    ins_pct = 85; ext_pct = 5;  dec_pct = 5;
                end
                MIX_DRAIN: begin
                    ins_pct = 15; ext_pct = 65; dec_pct = 10;
                end
                default: begin
                    ins_pct = 30; ext_pct = 25; dec_pct = 25;
                end
            endcase
            repeat (phase_len) begin
                roll = $urandom_range(0, 99);
                if (roll < ins_pct)                          act = uapq_pkg::ACT_INSERT;
                else if (roll < ins_pct + ext_pct)           act = uapq_pkg::ACT_EXTRACT;
                else if (roll < ins_pct + ext_pct + dec_pct) act = uapq_pkg::ACT_DECREASE;
                else                                         act = uapq_pkg::ACT_CONTAINS;

                // Reuse a known vertex often for lookups, rarely for inserts
                if (inserted_ids.size() != 0 &&
                    $urandom_range(0, 99) < ((act == uapq_pkg::ACT_INSERT) ? 20 : 75)) begin
                    vid = inserted_ids[$urandom_range(0, inserted_ids.size() - 1)];
                end else begin
                    vid = uapq_pkg::VERTEX_W'($urandom);
                end
                if (act == uapq_pkg::ACT_INSERT) begin
                    inserted_ids.push_back(vid);
                    if (inserted_ids.size() > 2 * CAPACITY) void'(inserted_ids.pop_front());
                end

                // Small priorities give ties; corners and full range give the rest
                case ($urandom_range(0, 3))
                    0: prio = $urandom;
                    1: begin
                        case ($urandom_range(0, 3))
                            0:       prio = 32'h8000_0000;
                            1:       prio = 32'h7FFF_FFFF;
                            2:       prio = 32'h0000_0000;
                            default: prio = 32'hFFFF_FFFF;
                        endcase
                    end
                    default: prio = 32'($urandom_range(0, 16)) - 32'd8;
                endcase

                issue(act, vid, prio);
            end
            sent += phase_len;
            phase++;
        end

        @(negedge aclk);
        s_tvalid <= 1'b0;

        // Drain outstanding results, then watch for strays
        while (results_owed != 0) @(posedge aclk);
        repeat (CAPACITY + 10) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/uapq_pkg.sv
rtl/uapq_ram.sv
rtl/uapq_ctrl.sv
rtl/uapq_dp.sv
rtl/unsorted_array_priority_queue.sv
tb/uapq_result_checker.sv
tb/unsorted_array_priority_queue_tb.sv
